FILE: rtl/pp_pkg.sv
// ----------------------------------------------------------------------------
// pp_pkg: shared types and constants for partition_percentile
// sizes of the value store, payload types and the Q16 unit constant
// ----------------------------------------------------------------------------
package pp_pkg;

   // value store capacity and derived index widths
   localparam int MAX_VALUES = 1024;
   localparam int ADDR_W     = $clog2(MAX_VALUES);
   localparam int CNT_W      = $clog2(MAX_VALUES + 1);

   // payload widths
   localparam int VALUE_W    = 32;
   localparam int FRAC_W     = 17;
   localparam int RESULT_W   = 48;
   localparam int QBITS      = 16;

   // one in Q16
   localparam logic [FRAC_W-1:0] Q16_ONE = FRAC_W'(1 << QBITS);

   // mode register encoding
   typedef enum logic {MODE_CONT = 1'b0, MODE_DISC = 1'b1} mode_type;

   typedef logic signed [VALUE_W-1:0]  value_type;
   typedef logic        [FRAC_W-1:0]   frac_type;
   typedef logic signed [RESULT_W-1:0] result_type;
   typedef logic        [ADDR_W-1:0]   addr_type;
   typedef logic        [CNT_W-1:0]    count_type;

endpackage

FILE: rtl/pp_if.sv
// ----------------------------------------------------------------------------
// pp_if: channel interfaces for partition_percentile
// request, response and control-register write channels, valid/ready each
// ----------------------------------------------------------------------------

// request channel: one partition value per transaction
interface pp_req_if;
   import pp_pkg::*;

   logic      valid;
   logic      ready;
   value_type value;
   logic      value_null;
   frac_type  fraction;
   logic      fraction_null;
   logic      last;

   modport source (output valid, value, value_null, fraction, fraction_null, last,
                   input ready);
   modport sink   (input valid, value, value_null, fraction, fraction_null, last,
                   output ready);
endinterface

// response channel: one percentile per partition
interface pp_rsp_if;
   import pp_pkg::*;

   logic       valid;
   logic       ready;
   result_type result_value;
   logic       result_null;
   logic       overflow;

   modport source (output valid, result_value, result_null, overflow, input ready);
   modport sink   (input valid, result_value, result_null, overflow, output ready);
endinterface

// control register write channel
interface pp_csr_if;
   logic valid;
   logic ready;
   logic mode;

   modport source (output valid, mode, input ready);
   modport sink   (input valid, mode, output ready);
endinterface

FILE: rtl/pp_ram.sv
// ----------------------------------------------------------------------------
// pp_ram: generic single-clock ram
// one write port, one read port with registered read data
// ----------------------------------------------------------------------------
module pp_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rd_data <= mem[rd_addr];
   end

endmodule

FILE: rtl/partition_percentile.sv
// ----------------------------------------------------------------------------
// partition_percentile: continuous / discrete percentile of a sorted partition
// stores non-null values, then picks the percentile with one shared multiplier
// ----------------------------------------------------------------------------
//
//   channel | dir | transaction
//   --------+-----+------------------------------------------------------------
//   req     | in  | one sorted value, null flags, fraction, last marker
//   rsp     | out | one percentile (Q16), null flag, overflow flag
//   csr     | in  | mode register write (0 continuous, 1 discrete)
//
// values load at one per cycle into a 1024-entry ram (one write, one read port)
// after the last transaction the sequencer runs: continuous mode steps through
// MUL, CSPLIT, CV0 and, for a nonzero weight, CV1 and CADD; discrete mode through
// MUL, DLOAD and a DCMP walk to the hit; a null result MUL only; all end in FIN
// req stalls while the sequencer runs; the result sits in an output register
// reset is synchronous and clears control only, no ram clearing pass
// csr is always ready; writes are expected only while idle
//
module partition_percentile (
   input  logic clock,
   input  logic reset,
   pp_req_if.sink   req,
   pp_rsp_if.source rsp,
   pp_csr_if.sink   csr
);
   import pp_pkg::*;

   // sequencer states
   localparam logic [3:0] S_LOAD   = 4'd0;
   localparam logic [3:0] S_MUL    = 4'd1;
   localparam logic [3:0] S_CSPLIT = 4'd2;
   localparam logic [3:0] S_CV0    = 4'd3;
   localparam logic [3:0] S_CV1    = 4'd4;
   localparam logic [3:0] S_CADD   = 4'd5;
   localparam logic [3:0] S_DLOAD  = 4'd6;
   localparam logic [3:0] S_DCMP   = 4'd7;
   localparam logic [3:0] S_FIN    = 4'd8;

   localparam int PROD_W = VALUE_W + FRAC_W;      // product register width
   localparam int NEED_W = CNT_W + QBITS;         // p*n and (i+1)<<16 width

   // control state
   logic [3:0]  state_ff, state_in;
   count_type   count_ff, count_in;
   logic        first_ff, first_in;
   logic        ovf_seen_ff, ovf_seen_in;
   logic        mode_ff, mode_in;
   logic        rsp_valid_ff, rsp_valid_in;

   // working registers
   frac_type    frac_ff, frac_in;
   logic        fnull_ff, fnull_in;
   count_type   n_ff, n_in;
   logic        ovf_ff, ovf_in;
   addr_type    idx_ff, idx_in;
   logic [QBITS-1:0] t_ff, t_in;
   value_type   cur_ff, cur_in;
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   result_type  acc_ff, acc_in;
   result_type  res_ff, res_in;
   logic        res_null_ff, res_null_in;
   result_type  rsp_value_ff, rsp_value_in;
   logic        rsp_null_ff, rsp_null_in;
   logic        rsp_ovf_ff, rsp_ovf_in;

   // ram ports
   logic      ram_we;
   addr_type  ram_waddr;
   addr_type  ram_raddr;
   value_type ram_rdata;

   // shared multiplier
   logic signed [VALUE_W-1:0]     mul_a;
   logic        [FRAC_W-1:0]      mul_b;
   logic signed [VALUE_W+FRAC_W:0] mul_prod;

   // misc combinational
   logic      req_take;
   logic      store_ok;
   count_type count_next;
   count_type idx_plus1;
   logic      last_elem;
   logic      group_end;
   logic      disc_hit;
   logic      out_free;

   assign req_take  = req.valid & req.ready;
   assign req.ready = (state_ff == S_LOAD);
   assign csr.ready = 1'b1;

   assign rsp.valid        = rsp_valid_ff;
   assign rsp.result_value = rsp_value_ff;
   assign rsp.result_null  = rsp_null_ff;
   assign rsp.overflow     = rsp_ovf_ff;

   // store admission
   assign store_ok   = (count_ff < CNT_W'(MAX_VALUES));
   assign count_next = (!req.value_null && store_ok) ? count_ff + CNT_W'(1) : count_ff;
   assign ram_we     = req_take & ~req.value_null & store_ok;
   assign ram_waddr  = count_ff[ADDR_W-1:0];

   // discrete walk compare
   assign idx_plus1 = CNT_W'(idx_ff) + CNT_W'(1);
   assign last_elem = (idx_plus1 == n_ff);
   assign group_end = last_elem || (ram_rdata != cur_ff);
   assign disc_hit  = ({idx_plus1, QBITS'(0)} >= prod_ff[NEED_W-1:0]);

   assign out_free = ~rsp_valid_ff | rsp.ready;

   // multiplier operand select
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (state_ff)
         S_MUL: begin
            mul_a = VALUE_W'($signed({1'b0, frac_ff}));
            mul_b = (mode_ff == MODE_DISC) ? FRAC_W'(n_ff) : FRAC_W'(n_ff - CNT_W'(1));
         end
         S_CV0: begin
            mul_a = ram_rdata;
            mul_b = Q16_ONE - FRAC_W'(t_ff);
         end
         S_CV1: begin
            mul_a = ram_rdata;
            mul_b = FRAC_W'(t_ff);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign mul_prod = mul_a * $signed({1'b0, mul_b});

   // ram read address
   always_comb begin
      unique case (state_ff)
         S_MUL:    ram_raddr = '0;
         S_CSPLIT: ram_raddr = prod_ff[ADDR_W+QBITS-1:QBITS];
         S_CV0:    ram_raddr = idx_ff + ADDR_W'(1);
         S_DLOAD:  ram_raddr = idx_ff + ADDR_W'(1);
         S_DCMP:   ram_raddr = idx_ff + ADDR_W'(2);
         default:  ram_raddr = idx_ff;
      endcase
   end

   // sequencer and datapath next state
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      first_in     = first_ff;
      ovf_seen_in  = ovf_seen_ff;
      mode_in      = mode_ff;
      frac_in      = frac_ff;
      fnull_in     = fnull_ff;
      n_in         = n_ff;
      ovf_in       = ovf_ff;
      idx_in       = idx_ff;
      t_in         = t_ff;
      cur_in       = cur_ff;
      prod_in      = prod_ff;
      acc_in       = acc_ff;
      res_in       = res_ff;
      res_null_in  = res_null_ff;
      rsp_value_in = rsp_value_ff;
      rsp_null_in  = rsp_null_ff;
      rsp_ovf_in   = rsp_ovf_ff;
      rsp_valid_in = rsp_valid_ff;

      // mode register write
      if (csr.valid && csr.ready) begin
         mode_in = csr.mode;
      end

      // response handshake
      if (rsp.valid && rsp.ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_LOAD: begin
            if (req_take) begin
               // latch p from the first transaction of the partition
               if (first_ff) begin
                  frac_in  = (req.fraction > Q16_ONE) ? Q16_ONE : req.fraction;
                  fnull_in = req.fraction_null;
                  first_in = 1'b0;
               end
               count_in = count_next;
               if (!req.value_null && !store_ok) begin
                  ovf_seen_in = 1'b1;
               end
               if (req.last) begin
                  n_in        = count_next;
                  ovf_in      = ovf_seen_ff | (~req.value_null & ~store_ok);
                  count_in    = '0;
                  ovf_seen_in = 1'b0;
                  first_in    = 1'b1;
                  if (first_ff) begin
                     fnull_in = req.fraction_null;
                  end
                  state_in    = S_MUL;
               end
            end
         end
         S_MUL: begin
            idx_in = '0;
            if (fnull_ff || n_ff == '0) begin
               // null result
               res_in      = '0;
               res_null_in = 1'b1;
               state_in    = S_FIN;
            end else begin
               res_null_in = 1'b0;
               prod_in     = mul_prod[PROD_W-1:0];
               state_in    = (mode_ff == MODE_DISC) ? S_DLOAD : S_CSPLIT;
            end
         end
         S_CSPLIT: begin
            // floor index and fractional weight of p*(n-1)
            idx_in   = prod_ff[ADDR_W+QBITS-1:QBITS];
            t_in     = prod_ff[QBITS-1:0];
            state_in = S_CV0;
         end
         S_CV0: begin
            prod_in = mul_prod[PROD_W-1:0];
            if (t_ff == '0) begin
               res_in   = mul_prod[RESULT_W-1:0];
               state_in = S_FIN;
            end else begin
               state_in = S_CV1;
            end
         end
         S_CV1: begin
            acc_in   = prod_ff[RESULT_W-1:0];
            prod_in  = mul_prod[PROD_W-1:0];
            state_in = S_CADD;
         end
         S_CADD: begin
            res_in   = acc_ff + prod_ff[RESULT_W-1:0];
            state_in = S_FIN;
         end
         S_DLOAD: begin
            cur_in   = ram_rdata;
            state_in = S_DCMP;
         end
         S_DCMP: begin
            // end of a tie group whose cumulative share reaches p
            if (group_end && disc_hit) begin
               res_in   = {cur_ff, QBITS'(0)};
               state_in = S_FIN;
            end else begin
               cur_in = ram_rdata;
               idx_in = idx_ff + ADDR_W'(1);
            end
         end
         S_FIN: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_value_in = res_ff;
               rsp_null_in  = res_null_ff;
               rsp_ovf_in   = ovf_ff;
               state_in     = S_LOAD;
            end
         end
         default: begin
            state_in = S_LOAD;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_LOAD;
         count_ff     <= '0;
         first_ff     <= 1'b1;
         ovf_seen_ff  <= 1'b0;
         mode_ff      <= MODE_CONT;
         rsp_valid_ff <= 1'b0;
         frac_ff      <= '0;
         fnull_ff     <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         first_ff     <= first_in;
         ovf_seen_ff  <= ovf_seen_in;
         mode_ff      <= mode_in;
         rsp_valid_ff <= rsp_valid_in;
         frac_ff      <= frac_in;
         fnull_ff     <= fnull_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      n_ff         <= n_in;
      ovf_ff       <= ovf_in;
      idx_ff       <= idx_in;
      t_ff         <= t_in;
      cur_ff       <= cur_in;
      prod_ff      <= prod_in;
      acc_ff       <= acc_in;
      res_ff       <= res_in;
      res_null_ff  <= res_null_in;
      rsp_value_ff <= rsp_value_in;
      rsp_null_ff  <= rsp_null_in;
      rsp_ovf_ff   <= rsp_ovf_in;
   end

   // value store
   pp_ram #(
      .WIDTH (VALUE_W),
      .DEPTH (MAX_VALUES)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (req.value),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   // checks

   // the sequencer takes over right after the last transaction
   a_last_stalls: assert property (@(posedge clock) disable iff (reset)
      (req.valid && req.ready && req.last) |=> !req.ready)
      else $error("request accepted right after a last transaction");

   // the fill count never passes capacity
   a_count_cap: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_VALUES))
      else $error("fill count beyond capacity");

   // a null result carries a zero value
   a_null_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && rsp.result_null) |-> (rsp.result_value == '0))
      else $error("null result with nonzero value");

   // a response appears only after the sequencer finishes
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == S_FIN))
      else $error("response raised outside the finish state");

endmodule
